FILE: rtl/toc_pkg.sv
package toc_pkg;

  // Default cap on option area bytes per packet
  localparam int MAX_OPTION_BYTES_DEF = 40;

  // Input beat: one byte of the option area
  typedef struct packed {
    logic [7:0] option_byte;
    logic       byte_valid;
    logic       last_byte;
  } toc_in_t;

  // Result beat: one classified option
  typedef struct packed {
    logic [3:0] token;
    logic [7:0] shift_value;
    logic       area_done;
  } toc_out_t;

  // Token codes
  localparam logic [3:0] TOK_NONE       = 4'd0;
  localparam logic [3:0] TOK_END        = 4'd1;
  localparam logic [3:0] TOK_BAD_END    = 4'd2;
  localparam logic [3:0] TOK_NOP        = 4'd3;
  localparam logic [3:0] TOK_MSS        = 4'd4;
  localparam logic [3:0] TOK_BAD_MSS    = 4'd5;
  localparam logic [3:0] TOK_SACKOK     = 4'd6;
  localparam logic [3:0] TOK_TS         = 4'd7;
  localparam logic [3:0] TOK_BAD_TS     = 4'd8;
  localparam logic [3:0] TOK_WSCALE     = 4'd9;
  localparam logic [3:0] TOK_MPTCP      = 4'd10;
  localparam logic [3:0] TOK_TFO_COOKIE = 4'd11;
  localparam logic [3:0] TOK_TFO_EMPTY  = 4'd12;
  localparam logic [3:0] TOK_OWN        = 4'd13;
  localparam logic [3:0] TOK_UNEXPECTED = 4'd14;
  localparam logic [3:0] TOK_UNKNOWN    = 4'd15;

  // Option kinds
  localparam logic [7:0] KIND_EOL    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] KIND_SACKOK = 8'd4;
  localparam logic [7:0] KIND_SACK   = 8'd5;
  localparam logic [7:0] KIND_ECHO   = 8'd6;
  localparam logic [7:0] KIND_ECHOR  = 8'd7;
  localparam logic [7:0] KIND_TS     = 8'd8;
  localparam logic [7:0] KIND_POCP   = 8'd9;
  localparam logic [7:0] KIND_POSP   = 8'd10;
  localparam logic [7:0] KIND_ALTCS  = 8'd14;
  localparam logic [7:0] KIND_ALTCSD = 8'd15;
  localparam logic [7:0] KIND_TCPTRL = 8'd18;
  localparam logic [7:0] KIND_MD5    = 8'd19;
  localparam logic [7:0] KIND_QSR    = 8'd27;
  localparam logic [7:0] KIND_UTO    = 8'd28;
  localparam logic [7:0] KIND_MPTCP  = 8'd30;
  localparam logic [7:0] KIND_TFO    = 8'd34;
  localparam logic [7:0] KIND_OWN    = 8'd64;
  localparam logic [7:0] KIND_EXP1   = 8'd253;
  localparam logic [7:0] KIND_EXP2   = 8'd254;

  // Fixed field values
  localparam logic [7:0] MSS_LEN = 8'd4;
  localparam logic [7:0] TS_LEN  = 8'h0a;

  // Parse phases
  localparam logic [1:0] PH_KIND = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

endpackage

FILE: rtl/toc_parser.sv
module toc_parser #(
  parameter int MaxBytes = toc_pkg::MAX_OPTION_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  toc_pkg::toc_in_t beat,
  output logic             res_valid,
  output toc_pkg::toc_out_t res
);
  import toc_pkg::*;

  localparam int CntW = $clog2(MaxBytes + 1);

  logic [1:0]      phase_r, phase_nxt;
  logic [7:0]      kind_r, kind_nxt;
  logic [1:0]      offset_r, offset_nxt;
  logic [7:0]      skip_r, skip_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [3:0]      tok;
  logic [7:0]      shift;
  logic [7:0]      b;

  assign b = beat.option_byte;

  // Per-byte parse step plus area close
  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    offset_nxt = offset_r;
    skip_nxt   = skip_r;
    count_nxt  = count_r;
    tok        = TOK_NONE;
    shift      = 8'd0;

    if (beat.byte_valid && (count_r < CntW'(MaxBytes))) begin
      count_nxt = count_r + 1'b1;
      case (phase_r)
        PH_KIND: begin
          kind_nxt   = b;
          offset_nxt = 2'd0;
          case (b)
            KIND_NOP: begin
              tok = TOK_NOP;
            end
            KIND_SACKOK: begin
              tok = TOK_SACKOK; skip_nxt = 8'd1; phase_nxt = PH_SKIP;
            end
            KIND_OWN: begin
              tok = TOK_OWN; skip_nxt = 8'd1; phase_nxt = PH_SKIP;
            end
            KIND_ECHO, KIND_ECHOR: begin
              tok = TOK_UNEXPECTED; skip_nxt = 8'd5; phase_nxt = PH_SKIP;
            end
            KIND_POCP: begin
              tok = TOK_UNEXPECTED; skip_nxt = 8'd1; phase_nxt = PH_SKIP;
            end
            KIND_POSP, KIND_ALTCS, KIND_TCPTRL: begin
              tok = TOK_UNEXPECTED; skip_nxt = 8'd2; phase_nxt = PH_SKIP;
            end
            KIND_MD5: begin
              tok = TOK_UNEXPECTED; skip_nxt = 8'd17; phase_nxt = PH_SKIP;
            end
            KIND_QSR: begin
              tok = TOK_UNEXPECTED; skip_nxt = 8'd7; phase_nxt = PH_SKIP;
            end
            KIND_UTO: begin
              tok = TOK_UNEXPECTED; skip_nxt = 8'd3; phase_nxt = PH_SKIP;
            end
            default: begin
              if (b inside {KIND_EOL, KIND_MSS, KIND_TS, KIND_WSCALE, KIND_MPTCP,
                            KIND_TFO, KIND_SACK, KIND_ALTCSD, KIND_EXP1, KIND_EXP2}) begin
                phase_nxt = PH_BODY;
              end else begin
                tok = TOK_UNKNOWN; phase_nxt = PH_STOP;
              end
            end
          endcase
        end
        PH_BODY: begin
          case (kind_r)
            KIND_EOL: begin
              if (b != 8'd0) begin
                tok = TOK_BAD_END; phase_nxt = PH_STOP;
              end else begin
                offset_nxt = offset_r + 2'd1;
                if (offset_r == 2'd2) begin
                  tok = TOK_END; phase_nxt = PH_STOP;
                end
              end
            end
            KIND_MSS: begin
              if (b == MSS_LEN) begin
                tok = TOK_MSS; skip_nxt = 8'd2; phase_nxt = PH_SKIP;
              end else begin
                tok = TOK_BAD_MSS; phase_nxt = PH_STOP;
              end
            end
            KIND_TS: begin
              if (b == TS_LEN) begin
                tok = TOK_TS; skip_nxt = 8'd8; phase_nxt = PH_SKIP;
              end else begin
                tok = TOK_BAD_TS; phase_nxt = PH_STOP;
              end
            end
            KIND_WSCALE: begin
              if (offset_r == 2'd0) begin
                offset_nxt = 2'd1;
              end else begin
                tok = TOK_WSCALE; shift = b; phase_nxt = PH_KIND;
              end
            end
            default: begin
              // Length-coded option: a length under two stops the walk
              if (b < 8'd2) begin
                tok = TOK_UNKNOWN; phase_nxt = PH_STOP;
              end else begin
                skip_nxt  = b - 8'd2;
                phase_nxt = (b == 8'd2) ? PH_KIND : PH_SKIP;
                if (kind_r == KIND_MPTCP) begin
                  tok = TOK_MPTCP;
                end else if (kind_r == KIND_TFO) begin
                  tok = (b > 8'd2) ? TOK_TFO_COOKIE : TOK_TFO_EMPTY;
                end else begin
                  tok = TOK_UNEXPECTED;
                end
              end
            end
          endcase
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 8'd1;
          if (skip_r == 8'd1) begin
            phase_nxt = PH_KIND;
          end
        end
        default: begin
        end
      endcase
    end

    // Area close: settle a pending option as if zero bytes followed
    if (beat.last_byte) begin
      if (tok == TOK_NONE && phase_nxt == PH_BODY) begin
        case (kind_nxt)
          KIND_EOL:    tok = TOK_END;
          KIND_MSS:    tok = TOK_BAD_MSS;
          KIND_TS:     tok = TOK_BAD_TS;
          KIND_WSCALE: tok = TOK_WSCALE;
          default:     tok = TOK_UNKNOWN;
        endcase
      end
      phase_nxt  = PH_KIND;
      kind_nxt   = 8'd0;
      offset_nxt = 2'd0;
      skip_nxt   = 8'd0;
      count_nxt  = '0;
    end
  end

  assign res_valid       = beat.last_byte || (tok != TOK_NONE);
  assign res.token       = tok;
  assign res.shift_value = (tok == TOK_WSCALE) ? shift : 8'd0;
  assign res.area_done   = beat.last_byte;

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_KIND;
      kind_r   <= 8'd0;
      offset_r <= 2'd0;
      skip_r   <= 8'd0;
      count_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      offset_r <= offset_nxt;
      skip_r   <= skip_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/tcp_option_classifier.sv
// TCP option classifier: takes the option area of a SYN-ACK as one byte per beat on
// in_data (byte_valid low marks an empty area, last_byte closes the area) and emits one
// token beat per recognized option on out_data. Every last_byte beat gives one result
// beat with area_done set, carrying the token it settles or none. Bytes after a stopping
// option, and bytes past MaxBytes in one area, are ignored; option bytes missing at the
// end of the area read as zero. One byte is taken every cycle unless in_stall is high;
// the parse step is combinational between the input register and the result register,
// so a result beat is registered as its byte leaves the input register. A byte that
// yields no token produces no result beat. The input stalls only while a result beat
// is held by out_stall and the waiting byte also yields a result.
module tcp_option_classifier #(
  parameter int MaxBytes = toc_pkg::MAX_OPTION_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  toc_pkg::toc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output toc_pkg::toc_out_t out_data
);
  import toc_pkg::*;

  toc_in_t  in_r;
  logic     in_valid_r, in_valid_nxt;
  toc_out_t out_r;
  logic     out_valid_r, out_valid_nxt;
  toc_out_t res;
  logic     res_valid;
  logic     adv;
  logic     out_free;

  // Output register frees when empty or being taken
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = in_valid_r && (!res_valid || out_free);
  assign in_stall = in_valid_r && !adv;

  toc_parser #(
    .MaxBytes(MaxBytes)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .beat     (in_r),
    .res_valid(res_valid),
    .res      (res)
  );

  // Valid tracking for both stages
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && !in_stall) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (adv && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/toc_checker.sv
module toc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input toc_pkg::toc_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input toc_pkg::toc_out_t out_data
);
  import toc_pkg::*;

  // Both channels come out of reset empty and open
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channels not clear after reset");

  // A stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input beat changed");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Only the closing beat may carry no token
  a_none_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token == TOK_NONE |-> out_data.area_done)
    else $error("empty token on a non-closing beat");

  // Shift field is zero except on window scale
  a_shift_only_ws: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.shift_value != 8'd0 |-> out_data.token == TOK_WSCALE)
    else $error("shift value outside window scale token");

endmodule

bind tcp_option_classifier toc_checker u_toc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
